// ===== hw/rtl/pcd_pkg.sv =====
`default_nettype none

package pcd_pkg;

   // Field widths
   localparam int ACTION_W   = 2;
   localparam int COORD_W    = 31;
   localparam int SPAN_W     = 20;
   localparam int CLIP_W     = 16;
   localparam int CODE_W     = 3;
   localparam int QUERY_W    = 10;
   localparam int COUNT_W    = 16;
   localparam int LENGTH_W   = 11;
   localparam int SLOT_W     = 11;
   localparam int SKIP_W     = 32;
   localparam int ALU_W      = 33;
   localparam int BASE_KINDS = 5;
   localparam int KIND_W     = 3;

   // APB port
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   // Register indexes (paddr[2])
   localparam logic REG_WINDOW_BEGIN  = 1'b0;
   localparam logic REG_WINDOW_LENGTH = 1'b1;

   localparam logic [COORD_W-1:0]  WINDOW_BEGIN_RESET  = '0;
   localparam logic [LENGTH_W-1:0] WINDOW_LENGTH_RESET = 11'd1024;

   // Item actions
   localparam logic [ACTION_W-1:0] ACT_READ_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ_BASE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY      = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 2'd3;

   // Base codes
   localparam logic [CODE_W-1:0] CODE_N     = 3'd3;
   localparam logic [CODE_W-1:0] CODE_LIMIT = 3'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [KIND_W-1:0]  KIND_LAST = 3'd4;

   typedef logic [BASE_KINDS-1:0][COUNT_W-1:0] count_row_type;

   typedef struct packed {
      logic [COORD_W-1:0]  window_begin;
      logic [LENGTH_W-1:0] window_length;
   } cfg_type;

   typedef struct packed {
      logic          cov_we;
      logic          row_we;
      logic [COUNT_W-1:0] cov_data;
      count_row_type row_data;
   } store_cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_LAST,
      ST_BOUNDS,
      ST_COV_RD,
      ST_COV_WR,
      ST_BASE_RD,
      ST_BASE_WR,
      ST_QRY_RD,
      ST_QRY_CMP,
      ST_QRY_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pcd_if.sv =====
`default_nettype none

interface pcd_req_if import pcd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [COORD_W-1:0]  read_begin;
   logic [SPAN_W-1:0]   ref_span;
   logic [CLIP_W-1:0]   clip_count;
   logic [CODE_W-1:0]   base_code;
   logic [QUERY_W-1:0]  query_index;

   modport source (output valid, action, read_begin, ref_span, clip_count, base_code,
                   query_index, input ready);
   modport sink (input valid, action, read_begin, ref_span, clip_count, base_code,
                 query_index, output ready);
endinterface

interface pcd_rsp_if import pcd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] coverage;
   logic [CODE_W-1:0]  consensus_base;
   logic               has_bases;

   modport source (output valid, coverage, consensus_base, has_bases, input ready);
   modport sink (input valid, coverage, consensus_base, has_bases, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcd_csr.sv =====
`default_nettype none

module pcd_csr import pcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_WINDOW_BEGIN:  cfg_in.window_begin  = pwdata[COORD_W-1:0];
            REG_WINDOW_LENGTH: cfg_in.window_length = pwdata[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WINDOW_BEGIN:  prdata = APB_DATA_W'(cfg_ff.window_begin);
         REG_WINDOW_LENGTH: prdata = APB_DATA_W'(cfg_ff.window_length);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_begin  <= WINDOW_BEGIN_RESET;
         cfg_ff.window_length <= WINDOW_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pcd_store.sv =====
`default_nettype none

module pcd_store import pcd_pkg::*; #(
   parameter  int WINDOW_SIZE = 1024,
   localparam int ADDR_WIDTH  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1
) (
   input  logic                  clock,
   input  logic [ADDR_WIDTH-1:0] addr,
   input  store_cmd_type         cmd,
   output logic [COUNT_W-1:0]    cov_rd,
   output count_row_type         row_rd
);

   logic [COUNT_W-1:0] cov_mem [WINDOW_SIZE];
   count_row_type      row_mem [WINDOW_SIZE];
   logic [COUNT_W-1:0] cov_rd_ff;
   count_row_type      row_rd_ff;

   assign cov_rd = cov_rd_ff;
   assign row_rd = row_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.cov_we) begin
         cov_mem[addr] <= cmd.cov_data;
      end
      cov_rd_ff <= cov_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.row_we) begin
         row_mem[addr] <= cmd.row_data;
      end
      row_rd_ff <= row_mem[addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pileup_consensus_depth_unit.sv =====
`default_nettype none

// Pileup coverage and majority-base store over a reference window.
// req_if takes items: read start (begin, span, clip), read base, query, clear.
// rsp_if gives one transfer per query: coverage, consensus base, has_bases.
// The APB port sets window_begin (0x0) and window_length (0x4); write only
// while the block is idle.
// Steps per item, from its transfer until the next item can be accepted:
//   read start : difference, end and bounds, then a read and a write back
//                per covered window position
//   read base  : a row read, and a row write back when the base is counted
//   query      : row read, five compares (skipped out of range), result load
//   clear      : one row zeroed per cycle
// One 33-bit adder serves all coordinate, skip and position arithmetic.
// Reset runs the same clearing pass with ready low; configuration writes are
// taken during the pass.
// A finished query result holds in an output register; the next item is
// accepted meanwhile, and a following query waits in its last state until
// the held result has been taken.

module pileup_consensus_depth_unit import pcd_pkg::*; #(
   parameter int WINDOW_SIZE = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   pcd_req_if.sink               req_if,
   pcd_rsp_if.source             rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_WIDTH = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int LEN_CAP    = (WINDOW_SIZE > 2047) ? 2047 : WINDOW_SIZE;
   localparam logic [ADDR_WIDTH-1:0] SWEEP_LAST = ADDR_WIDTH'(WINDOW_SIZE - 1);

   cfg_type cfg;

   pcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Store port
   logic [ADDR_WIDTH-1:0] mem_addr;
   store_cmd_type         store_cmd;
   logic [COUNT_W-1:0]    cov_rd;
   count_row_type         row_rd;

   pcd_store #(.WINDOW_SIZE(WINDOW_SIZE)) u_store (
      .clock  (clock),
      .addr   (mem_addr),
      .cmd    (store_cmd),
      .cov_rd (cov_rd),
      .row_rd (row_rd)
   );

   // Sequencer state
   state_type             state_ff, state_in;
   logic [ADDR_WIDTH-1:0] sweep_ff, sweep_in;

   // Latched item
   logic [COORD_W-1:0] begin_ff, begin_in;
   logic [SPAN_W-1:0]  span_ff, span_in;
   logic [CLIP_W-1:0]  clip_ff, clip_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [QUERY_W-1:0] query_ff, query_in;

   // Read-start working values (two's complement, 33 bits)
   logic [ALU_W-1:0] first_ff, first_in;
   logic [ALU_W-1:0] last_ff, last_in;

   // Base walk
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] end_ff, end_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic [SLOT_W-1:0] cursor_ff, cursor_in;

   // Majority search
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [COUNT_W-1:0] top_ff, top_in;
   logic [CODE_W-1:0]  best_ff, best_in;
   logic [COUNT_W-1:0] qcov_ff, qcov_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_cov_ff, rsp_cov_in;
   logic [CODE_W-1:0]  rsp_base_ff, rsp_base_in;
   logic               rsp_has_ff, rsp_has_in;

   // Shared adder
   logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_cin;

   assign alu_sum = alu_a + alu_b + ALU_W'(alu_cin);

   // Effective window length
   logic [SLOT_W-1:0] len_eff;
   assign len_eff = (32'(cfg.window_length) > 32'(LEN_CAP)) ? SLOT_W'(LEN_CAP)
                                                          : cfg.window_length;

   // Window position to memory address
   logic [SLOT_W-1:0]            pos;
   logic [SLOT_W+ADDR_WIDTH-1:0] pos_wide;
   assign pos_wide = {{ADDR_WIDTH{1'b0}}, pos};

   // Clipping of the read interval
   logic             first_neg;
   logic [ALU_W-1:0] len_wide, lo_wide, hi_wide;
   logic             walk_empty;

   assign first_neg  = first_ff[ALU_W-1];
   assign len_wide   = ALU_W'(len_eff);
   assign lo_wide    = first_neg ? '0 : first_ff;
   assign hi_wide    = ($signed(last_ff) > $signed(len_wide)) ? len_wide : last_ff;
   assign walk_empty = ($signed(last_ff) <= $signed(ALU_W'(0))) ||
                       ($signed(lo_wide) >= $signed(hi_wide));

   logic         accept;
   logic         rsp_free;
   count_row_type row_inc;

   assign accept   = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // Row with the latched base's count bumped, saturating
   always_comb begin
      row_inc = row_rd;
      if (code_ff < CODE_LIMIT) begin
         if (row_rd[code_ff] != COUNT_MAX) begin
            row_inc[code_ff] = row_rd[code_ff] + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      begin_in     = begin_ff;
      span_in      = span_ff;
      clip_in      = clip_ff;
      code_in      = code_ff;
      query_in     = query_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      end_in       = end_ff;
      skip_in      = skip_ff;
      cursor_in    = cursor_ff;
      kind_in      = kind_ff;
      top_in       = top_ff;
      best_in      = best_ff;
      qcov_in      = qcov_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_cov_in   = rsp_cov_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_has_in   = rsp_has_ff;

      alu_a   = '0;
      alu_b   = '0;
      alu_cin = 1'b0;
      pos     = {1'b0, query_ff};

      store_cmd          = '0;
      store_cmd.cov_data = cov_rd;
      store_cmd.row_data = row_inc;

      req_if.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one row of both memories per cycle
            store_cmd.cov_we   = 1'b1;
            store_cmd.row_we   = 1'b1;
            store_cmd.cov_data = '0;
            store_cmd.row_data = '0;
            sweep_in           = sweep_ff + ADDR_WIDTH'(1);
            if (sweep_ff == SWEEP_LAST) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               begin_in = req_if.read_begin;
               span_in  = req_if.ref_span;
               clip_in  = req_if.clip_count;
               code_in  = req_if.base_code;
               query_in = req_if.query_index;
               unique case (req_if.action)
                  ACT_READ_START: state_in = ST_DIFF;
                  ACT_READ_BASE:  state_in = ST_BASE_RD;
                  ACT_QUERY:      state_in = ST_QRY_RD;
                  ACT_CLEAR: begin
                     slot_in  = '0;
                     end_in   = '0;
                     skip_in  = '0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_DIFF: begin
            // first = read_begin - window_begin
            alu_a    = ALU_W'(begin_ff);
            alu_b    = ~ALU_W'(cfg.window_begin);
            alu_cin  = 1'b1;
            first_in = alu_sum;
            state_in = ST_LAST;
         end

         ST_LAST: begin
            alu_a    = first_ff;
            alu_b    = ALU_W'(span_ff);
            last_in  = alu_sum;
            state_in = ST_BOUNDS;
         end

         ST_BOUNDS: begin
            // skip = clip + overhang ahead of the window
            alu_a   = ALU_W'(clip_ff);
            alu_b   = first_neg ? ~first_ff : '0;
            alu_cin = first_neg;
            if (walk_empty) begin
               slot_in  = '0;
               end_in   = '0;
               skip_in  = '0;
               state_in = ST_IDLE;
            end else begin
               slot_in   = lo_wide[SLOT_W-1:0];
               cursor_in = lo_wide[SLOT_W-1:0];
               end_in    = hi_wide[SLOT_W-1:0];
               skip_in   = alu_sum[SKIP_W-1:0];
               state_in  = ST_COV_RD;
            end
         end

         ST_COV_RD: begin
            pos      = cursor_ff;
            state_in = ST_COV_WR;
         end

         ST_COV_WR: begin
            // Write back saturated coverage, advance the cursor
            pos                = cursor_ff;
            store_cmd.cov_we   = 1'b1;
            store_cmd.cov_data = (cov_rd == COUNT_MAX) ? cov_rd : cov_rd + COUNT_W'(1);
            alu_a              = ALU_W'(cursor_ff);
            alu_cin            = 1'b1;
            cursor_in          = alu_sum[SLOT_W-1:0];
            state_in           = (alu_sum[SLOT_W-1:0] == end_ff) ? ST_IDLE : ST_COV_RD;
         end

         ST_BASE_RD: begin
            pos      = slot_ff;
            state_in = ST_IDLE;
            if (skip_ff != '0) begin
               // Drop this base, count down the skip
               alu_a   = ALU_W'(skip_ff);
               alu_b   = '1;
               skip_in = alu_sum[SKIP_W-1:0];
            end else if (slot_ff < end_ff) begin
               if (code_ff < CODE_LIMIT) begin
                  state_in = ST_BASE_WR;
               end else begin
                  alu_a   = ALU_W'(slot_ff);
                  alu_cin = 1'b1;
                  slot_in = alu_sum[SLOT_W-1:0];
               end
            end
         end

         ST_BASE_WR: begin
            pos              = slot_ff;
            store_cmd.row_we = 1'b1;
            alu_a            = ALU_W'(slot_ff);
            alu_cin          = 1'b1;
            slot_in          = alu_sum[SLOT_W-1:0];
            state_in         = ST_IDLE;
         end

         ST_QRY_RD: begin
            kind_in = '0;
            top_in  = '0;
            best_in = CODE_N;
            qcov_in = '0;
            if ({1'b0, query_ff} >= len_eff) begin
               state_in = ST_QRY_OUT;
            end else begin
               state_in = ST_QRY_CMP;
            end
         end

         ST_QRY_CMP: begin
            // One count per cycle; strict compare keeps the lowest code on ties
            if (kind_ff == '0) begin
               qcov_in = cov_rd;
            end
            if (row_rd[kind_ff] > top_ff) begin
               top_in  = row_rd[kind_ff];
               best_in = CODE_W'(kind_ff);
            end
            kind_in  = kind_ff + KIND_W'(1);
            state_in = (kind_ff == KIND_LAST) ? ST_QRY_OUT : ST_QRY_CMP;
         end

         ST_QRY_OUT: begin
            // Hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cov_in   = qcov_ff;
               rsp_base_in  = best_ff;
               rsp_has_in   = (top_ff != '0);
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      mem_addr = (state_ff == ST_CLEAR) ? sweep_ff : pos_wide[ADDR_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         slot_ff      <= '0;
         end_ff       <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         slot_ff      <= slot_in;
         end_ff       <= end_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      begin_ff    <= begin_in;
      span_ff     <= span_in;
      clip_ff     <= clip_in;
      code_ff     <= code_in;
      query_ff    <= query_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      cursor_ff   <= cursor_in;
      kind_ff     <= kind_in;
      top_ff      <= top_in;
      best_ff     <= best_in;
      qcov_ff     <= qcov_in;
      rsp_cov_ff  <= rsp_cov_in;
      rsp_base_ff <= rsp_base_in;
      rsp_has_ff  <= rsp_has_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.coverage       = rsp_cov_ff;
   assign rsp_if.consensus_base = rsp_base_ff;
   assign rsp_if.has_bases      = rsp_has_ff;

   // The base walk never runs past its end
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= end_ff)
      else $error("base walk slot beyond its end");

   // The coverage cursor stays inside the clipped interval
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COV_RD || state_ff == ST_COV_WR) |-> cursor_ff < end_ff)
      else $error("coverage cursor outside clipped interval");

   // A count row is written back only for a countable base
   a_row_write: assert property (@(posedge clock) disable iff (reset)
      store_cmd.row_we && state_ff != ST_CLEAR |-> code_ff < CODE_LIMIT)
      else $error("row write for an uncountable base");

   // An empty position reports N
   a_empty_is_n: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_ff |-> rsp_base_ff == CODE_N)
      else $error("empty position without N");

endmodule

`default_nettype wire
